// ===== hw/rtl/mobs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the motion observer.
`timescale 1ns / 1ps

package mobs_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 3'd4;

   // datapath operations, one per controller step
   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_D,
      OP_MUL_P,
      OP_ACC_P,
      OP_MUL_I,
      OP_ACC_I,
      OP_DIST,
      OP_TOTAL,
      OP_MUL_A,
      OP_SPEED,
      OP_MUL_H,
      OP_PRED,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   // saturate a 34-bit signed sum to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < 34'sh3_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product: round to nearest (ties up), then saturate
   function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p);
      logic signed [65:0] t;
      logic signed [49:0] s;
      logic signed [31:0] r;
      t = p + 66'sd32768;
      s = t[65:16];
      if (s > 50'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (s < 50'sh3_FFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mobs_ctrl.sv =====
// Sequencing state machine for the motion observer update.
`timescale 1ns / 1ps

module mobs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mobs_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_D,
      ST_MUL_P,
      ST_ACC_P,
      ST_MUL_I,
      ST_ACC_I,
      ST_DIST,
      ST_TOTAL,
      ST_MUL_A,
      ST_SPEED,
      ST_MUL_H,
      ST_PRED,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.op   = mobs_pkg::OP_NONE;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            cmd.op   = mobs_pkg::OP_MUL_D;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.op   = mobs_pkg::OP_MUL_P;
            state_in = ST_ACC_P;
         end
         ST_ACC_P: begin
            cmd.op   = mobs_pkg::OP_ACC_P;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.op   = mobs_pkg::OP_MUL_I;
            state_in = ST_ACC_I;
         end
         ST_ACC_I: begin
            cmd.op   = mobs_pkg::OP_ACC_I;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            cmd.op   = mobs_pkg::OP_DIST;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.op   = mobs_pkg::OP_TOTAL;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.op   = mobs_pkg::OP_MUL_A;
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.op   = mobs_pkg::OP_SPEED;
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            cmd.op   = mobs_pkg::OP_MUL_H;
            state_in = ST_PRED;
         end
         ST_PRED: begin
            cmd.op   = mobs_pkg::OP_PRED;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.op   = mobs_pkg::OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == mobs_pkg::OP_FINISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block not busy next cycle");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("finish step left while output still stalled");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response valid rose outside the finish step");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mobs_pkg::OP_FINISH) |=> rsp_valid_ff)
      else $error("finish step did not raise response valid");

endmodule

// ===== hw/rtl/mobs_dp.sv =====
// Observer datapath: gain registers, state, shared multiplier and result register.
`timescale 1ns / 1ps

module mobs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mobs_pkg::cmd_type                   cmd,
   input  logic                                csr_wr_en,
   input  logic [mobs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mobs_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic [15:0]                         req_meas_angle,
   input  logic signed [15:0]                  req_torque_cmd,
   output logic [15:0]                         rsp_angle_est,
   output logic signed [31:0]                  rsp_speed_est,
   output logic signed [31:0]                  rsp_disturbance_est
);

   // configuration
   logic signed [31:0] gain_d_ff, gain_p_ff, gain_i_ff, accel_scale_ff;
   logic [30:0]        half_period_ff;

   // observer state
   logic [15:0]        last_meas_ff, last_meas_in;
   logic [15:0]        angle_ff, angle_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] pred_ff, pred_in;
   logic signed [31:0] prop_ff, prop_in;
   logic signed [31:0] integ_ff, integ_in;

   // per-request working registers
   logic signed [31:0] err_ff, err_in;
   logic signed [15:0] torque_ff, torque_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic signed [31:0] dist_ff, dist_in;
   logic signed [31:0] total_ff, total_in;
   logic signed [31:0] speed_new_ff, speed_new_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [15:0]        out_angle_ff, out_angle_in;
   logic signed [31:0] out_speed_ff, out_speed_in;
   logic signed [31:0] out_dist_ff, out_dist_in;

   logic [15:0]        inc;
   logic signed [33:0] err_wide;
   logic signed [31:0] prod_q;
   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] speed_sum;
   logic [31:0]        pred_rnd;

   assign prod_q    = mobs_pkg::rnd_sat(prod_ff);
   assign speed_sum = {speed_new_ff[31], speed_new_ff} + {speed_ff[31], speed_ff};
   assign pred_rnd  = pred_ff + 32'h0000_8000;

   // measured increment wraps to a signed half turn by plain 16-bit subtraction
   assign inc      = req_meas_angle - last_meas_ff;
   assign err_wide = {{2{inc[15]}}, inc, 16'h0000} - {{2{pred_ff[31]}}, pred_ff};

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         mobs_pkg::OP_MUL_D: begin
            mul_a = {gain_d_ff[31], gain_d_ff};
            mul_b = {err_ff[31], err_ff};
         end
         mobs_pkg::OP_MUL_P: begin
            mul_a = {gain_p_ff[31], gain_p_ff};
            mul_b = {err_ff[31], err_ff};
         end
         mobs_pkg::OP_MUL_I: begin
            mul_a = {prop_ff[31], prop_ff};
            mul_b = {gain_i_ff[31], gain_i_ff};
         end
         mobs_pkg::OP_MUL_A: begin
            mul_a = {accel_scale_ff[31], accel_scale_ff};
            mul_b = {total_ff[31], total_ff};
         end
         mobs_pkg::OP_MUL_H: begin
            mul_a = {2'b00, half_period_ff};
            mul_b = speed_sum;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      last_meas_in = last_meas_ff;
      angle_in     = angle_ff;
      speed_in     = speed_ff;
      pred_in      = pred_ff;
      prop_in      = prop_ff;
      integ_in     = integ_ff;
      err_in       = err_ff;
      torque_in    = torque_ff;
      deriv_in     = deriv_ff;
      dist_in      = dist_ff;
      total_in     = total_ff;
      speed_new_in = speed_new_ff;
      out_angle_in = out_angle_ff;
      out_speed_in = out_speed_ff;
      out_dist_in  = out_dist_ff;
      if (cmd.load) begin
         last_meas_in = req_meas_angle;
         torque_in    = req_torque_cmd;
         err_in       = mobs_pkg::sat34(err_wide);
      end
      case (cmd.op)
         mobs_pkg::OP_MUL_P: begin
            deriv_in = prod_q;
         end
         mobs_pkg::OP_ACC_P: begin
            prop_in = mobs_pkg::sat34({{2{prop_ff[31]}}, prop_ff}
                                      + {{2{prod_q[31]}}, prod_q});
         end
         mobs_pkg::OP_ACC_I: begin
            integ_in = mobs_pkg::sat34({{2{integ_ff[31]}}, integ_ff}
                                       + {{2{prod_q[31]}}, prod_q});
         end
         mobs_pkg::OP_DIST: begin
            dist_in = mobs_pkg::sat34({{2{deriv_ff[31]}}, deriv_ff}
                                      + {{2{prop_ff[31]}}, prop_ff}
                                      + {{2{integ_ff[31]}}, integ_ff});
         end
         mobs_pkg::OP_TOTAL: begin
            total_in = mobs_pkg::sat34({{2{torque_ff[15]}}, torque_ff, 16'h0000}
                                       + {{2{dist_ff[31]}}, dist_ff});
         end
         mobs_pkg::OP_SPEED: begin
            speed_new_in = mobs_pkg::sat34({{2{speed_ff[31]}}, speed_ff}
                                           + {{2{prod_q[31]}}, prod_q});
         end
         mobs_pkg::OP_PRED: begin
            pred_in  = prod_q;
            speed_in = speed_new_ff;
         end
         mobs_pkg::OP_FINISH: begin
            angle_in     = angle_ff + pred_rnd[31:16];
            out_angle_in = angle_ff + pred_rnd[31:16];
            out_speed_in = speed_ff;
            out_dist_in  = dist_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_d_ff      <= '0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         accel_scale_ff <= '0;
         half_period_ff <= '0;
         last_meas_ff   <= '0;
         angle_ff       <= '0;
         speed_ff       <= '0;
         pred_ff        <= '0;
         prop_ff        <= '0;
         integ_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mobs_pkg::CSR_GAIN_D:      gain_d_ff      <= csr_wr_data;
               mobs_pkg::CSR_GAIN_P:      gain_p_ff      <= csr_wr_data;
               mobs_pkg::CSR_GAIN_I:      gain_i_ff      <= csr_wr_data;
               mobs_pkg::CSR_ACCEL_SCALE: accel_scale_ff <= csr_wr_data;
               mobs_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_wr_data[30:0];
               default: begin
               end
            endcase
         end
         last_meas_ff <= last_meas_in;
         angle_ff     <= angle_in;
         speed_ff     <= speed_in;
         pred_ff      <= pred_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      torque_ff    <= torque_in;
      deriv_ff     <= deriv_in;
      dist_ff      <= dist_in;
      total_ff     <= total_in;
      speed_new_ff <= speed_new_in;
      prod_ff      <= prod_in;
      out_angle_ff <= out_angle_in;
      out_speed_ff <= out_speed_in;
      out_dist_ff  <= out_dist_in;
   end

   assign rsp_angle_est       = out_angle_ff;
   assign rsp_speed_est       = out_speed_ff;
   assign rsp_disturbance_est = out_dist_ff;

endmodule

// ===== hw/rtl/motion_observer_step.sv =====
// Top level of the motion observer: one estimator update per request.
`timescale 1ns / 1ps

// Motion observer, one update per request. Each request carries a measured
// rotor angle (16-bit, full turn = 65536) and a signed commanded torque; each
// produces exactly one response with the estimated next angle, the estimated
// speed and the estimated disturbance torque (both signed Q16.16, saturating).
// A request is taken when req_valid is high and req_stall low; the block then
// works through one shared 33x33 signed multiplier (five products:
// derivative, proportional, integral, acceleration and the trapezoidal angle
// increment, each followed by a round/saturate step) and takes no new request
// until it is done with the last one. A finished response sits in an
// output register until the consumer takes it, and the next request is
// accepted meanwhile; it only waits at its last step if that register is
// still full. Gains are written through csr_wr_en/csr_index/csr_wr_data
// (0 gain_d, 1 gain_p, 2 gain_i, 3 accel_scale, 4 half_period; other indexes
// are ignored) and must be written only while no request is in flight.
// Reset clears all gains and observer state; the first measured angle after
// reset is compared against zero.

module motion_observer_step (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_meas_angle,
   input  logic signed [15:0]                  req_torque_cmd,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [15:0]                         rsp_angle_est,
   output logic signed [31:0]                  rsp_speed_est,
   output logic signed [31:0]                  rsp_disturbance_est,
   // gain registers
   input  logic                                csr_wr_en,
   input  logic [mobs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mobs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   // command bus from sequencer to datapath
   mobs_pkg::cmd_type cmd;

   // sequencer: walks the fixed operation order and owns both handshakes
   mobs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: gains, observer state, shared multiplier, response register
   mobs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_meas_angle      (req_meas_angle),
      .req_torque_cmd      (req_torque_cmd),
      .rsp_angle_est       (rsp_angle_est),
      .rsp_speed_est       (rsp_speed_est),
      .rsp_disturbance_est (rsp_disturbance_est)
   );

endmodule

// ===== bench/observer_check_pkg.sv =====
// Response checker for the motion observer: fixed-point estimator copy and pending-estimate queue.
`timescale 1ns / 1ps

package observer_check_pkg;

   typedef struct {
      logic [15:0]        angle;
      logic signed [31:0] speed;
      logic signed [31:0] disturb;
   } estimate_type;

   localparam logic signed [79:0] Q_MAX   = 80'sd2147483647;
   localparam logic signed [79:0] Q_MIN   = -80'sd2147483648;
   localparam logic signed [79:0] Q_ROUND = 80'sd32768;
   localparam logic signed [79:0] Q_ONE   = 80'sd65536;
   localparam int REPORT_LIMIT = 10;

   class observer_scoreboard;
      logic signed [31:0] gain_d, gain_p, gain_i, accel_scale;
      logic [30:0]        half_period;
      logic [15:0]        last_meas, angle_q;
      logic signed [31:0] speed_q, pred_inc, prop_acc, integ_acc;
      estimate_type       pending_estimates[$];
      int                 errors;

      function new();
         gain_d = '0;
         gain_p = '0;
         gain_i = '0;
         accel_scale = '0;
         half_period = '0;
         last_meas = '0;
         angle_q = '0;
         speed_q = '0;
         pred_inc = '0;
         prop_acc = '0;
         integ_acc = '0;
         errors = 0;
      endfunction

      function logic signed [31:0] clamp32(input logic signed [79:0] v);
         if (v > Q_MAX) return Q_MAX[31:0];
         if (v < Q_MIN) return Q_MIN[31:0];
         return v[31:0];
      endfunction

      // Q16.16 product, round half up, saturate
      function logic signed [31:0] qmul(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
         logic signed [79:0] x, y;
         x = a;
         y = b;
         return clamp32((x * y + Q_ROUND) >>> 16);
      endfunction

      function logic signed [31:0] sadd(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
         logic signed [79:0] x, y;
         x = a;
         y = b;
         return clamp32(x + y);
      endfunction

      function void write_reg(input logic [mobs_pkg::CSR_IDX_W-1:0] idx,
                              input logic [mobs_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mobs_pkg::CSR_GAIN_D:      gain_d = data;
            mobs_pkg::CSR_GAIN_P:      gain_p = data;
            mobs_pkg::CSR_GAIN_I:      gain_i = data;
            mobs_pkg::CSR_ACCEL_SCALE: accel_scale = data;
            mobs_pkg::CSR_HALF_PERIOD: half_period = data[30:0];
            default: ;
         endcase
      endfunction

      // advance the estimator by one accepted request and queue its estimate
      function void note_request(input logic [15:0] meas, input logic signed [15:0] torque);
         logic [15:0]        inc;
         logic signed [79:0] wide, hp, ssum;
         logic signed [31:0] err, deriv, disturb, total, speed_new;
         estimate_type       e;
         inc = meas - last_meas;
         last_meas = meas;
         wide = $signed(inc);
         err = clamp32(wide * Q_ONE - pred_inc);
         deriv = qmul(gain_d, err);
         prop_acc = sadd(prop_acc, qmul(gain_p, err));
         integ_acc = sadd(integ_acc, qmul(prop_acc, gain_i));
         wide = deriv;
         disturb = clamp32(wide + prop_acc + integ_acc);
         wide = torque;
         total = clamp32(wide * Q_ONE + disturb);
         speed_new = sadd(speed_q, qmul(accel_scale, total));
         hp = {49'd0, half_period};
         ssum = speed_new;
         ssum = ssum + speed_q;
         pred_inc = clamp32((hp * ssum + Q_ROUND) >>> 16);
         wide = pred_inc;
         wide = (wide + Q_ROUND) >>> 16;
         angle_q = angle_q + wide[15:0];
         speed_q = speed_new;
         e.angle = angle_q;
         e.speed = speed_q;
         e.disturb = disturb;
         pending_estimates.push_back(e);
      endfunction

      function void check_response(input logic [15:0] angle, input logic signed [31:0] speed,
                                   input logic signed [31:0] disturb);
         estimate_type e;
         if (pending_estimates.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response: angle %h speed %h disturbance %h",
                        angle, speed, disturb);
            return;
         end
         e = pending_estimates.pop_front();
         if (e.angle !== angle || e.speed !== speed || e.disturb !== disturb) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("mismatch: angle %h/%h speed %h/%h disturbance %h/%h (exp/got)",
                        e.angle, angle, e.speed, speed, e.disturb, disturb);
         end
      endfunction

      function int outstanding();
         return pending_estimates.size();
      endfunction
   endclass

endpackage

// ===== bench/tb.sv =====
// Top-level testbench for the motion observer step block.
`timescale 1ns / 1ps

module tb;

   import mobs_pkg::*;
   import observer_check_pkg::*;

   localparam int RANDOM_HALF   = 55;    // random requests per half phase
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [15:0]           req_meas_angle = '0;
   logic signed [15:0]    req_torque_cmd = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_angle_est;
   logic signed [31:0]    rsp_speed_est;
   logic signed [31:0]    rsp_disturbance_est;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   observer_scoreboard board;
   int                 idle_cycles = 0;
   logic [15:0]        stall_pattern = '0;
   int                 stall_left = 0;
   int                 stall_pos = 0;

   motion_observer_step u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_meas_angle      (req_meas_angle),
      .req_torque_cmd      (req_torque_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_angle_est       (rsp_angle_est),
      .rsp_speed_est       (rsp_speed_est),
      .rsp_disturbance_est (rsp_disturbance_est),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Sample every handshake at the rising edge. Check the response first: a
   // response taken at the same edge as a request always belongs to an older one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_angle_est, rsp_speed_est, rsp_disturbance_est);
         if (req_valid && !req_stall)
            board.note_request(req_meas_angle, req_torque_cmd);
         if (csr_wr_en)
            board.write_reg(csr_index, csr_wr_data);
      end
   end

   // Watchdog: end the run when no request or response moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: walk a 16-bit stall pattern, pick a new one every so often.
   // Clear one bit of every pattern so a stall never lasts forever; the
   // all-zero pattern gives stretches with no back-pressure at all.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '0;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = '1;
         endcase
         stall_pattern[$urandom_range(0, 15)] = 1'b0;
         stall_left = $urandom_range(16, 200);
      end
      rsp_stall <= stall_pattern[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
      stall_left--;
   end

   // Present one request and hold it until the block takes it; return at the
   // next falling edge with valid still high so a burst can continue.
   task automatic send_request(input logic [15:0] meas, input logic signed [15:0] torque);
      req_valid <= 1'b1;
      req_meas_angle <= meas;
      req_torque_cmd <= torque;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for the given number of cycles.
   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Drop valid and wait until every estimate is back, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   // Load a full gain set, preceded by a write to an unused index that the
   // block must ignore. Call only while the block is idle.
   task automatic program_gains(input logic [31:0] d, input logic [31:0] p,
                                input logic [31:0] i, input logic [31:0] a,
                                input logic [31:0] h);
      write_reg(CSR_HALF_PERIOD + 3'($urandom_range(1, 3)), $urandom);
      write_reg(CSR_GAIN_D, d);
      write_reg(CSR_GAIN_P, p);
      write_reg(CSR_GAIN_I, i);
      write_reg(CSR_ACCEL_SCALE, a);
      write_reg(CSR_HALF_PERIOD, h);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Random requests in bursts with random gaps. Most follow a rotor turning
   // at a steady rate with small noise and small torque, so the observer can
   // lock on; the rest are arbitrary angles and torques.
   task automatic run_random(input int count, input int drift);
      int          sent;
      int          burst;
      int          gap;
      int          t;
      logic [15:0] angle;
      logic [15:0] torque;
      sent = 0;
      angle = 16'($urandom);
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               t = int'($urandom_range(0, 127)) - 64;
               angle = angle + 16'(drift) + 16'(t);
               t = int'($urandom_range(0, 1023)) - 512;
               torque = 16'(t);
            end else begin
               angle = 16'($urandom);
               torque = 16'($urandom);
            end
            send_request(angle, torque);
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) hold_off(gap);
      end
   endtask

   // Two random halves with a full drain in between.
   task automatic run_phase(input int drift);
      run_random(RANDOM_HALF, drift);
      wait_drained();
      run_random(RANDOM_HALF, drift);
      wait_drained();
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // moderate gains, directed angle wrap and torque extremes
      program_gains(32'h0000_4000, 32'h0000_2000, 32'h0000_0800,
                    32'h0000_0400, 32'h0000_8000);
      send_request(16'h0100, 16'h0000);   // first sample against zero
      send_request(16'h8100, 16'h0064);   // exact half turn forward
      send_request(16'h0100, 16'hFF9C);   // exact half turn again
      send_request(16'hFFFF, 16'h7FFF);
      send_request(16'h0000, 16'h8000);
      send_request(16'h7FFF, 16'h0001);
      send_request(16'hFFFF, 16'hFFFF);   // half turn across the top
      send_request(16'h8000, 16'h0000);
      send_request(16'h0000, 16'h0000);
      send_request(16'h0001, 16'h7FFF);
      send_request(16'hFFFE, 16'h8000);
      send_request(16'h5555, 16'h5555);
      send_request(16'hAAAA, 16'hAAAA);
      wait_drained();
      run_phase(40);

      // largest gains: every path saturates; half period with the spare bit set
      program_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(16'h8000, 16'h7FFF);
      send_request(16'h0000, 16'h8000);
      send_request(16'hFFFF, 16'h7FFF);
      send_request(16'h7FFF, 16'h8000);
      wait_drained();
      run_phase(-300);

      // most negative gains, zero half period: the estimated angle holds
      program_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h0000_0000);
      send_request(16'h8000, 16'h8000);
      send_request(16'h0000, 16'h7FFF);
      send_request(16'h1234, 16'h0000);
      send_request(16'h9234, 16'hFFFF);
      wait_drained();
      run_phase(1000);

      // arbitrary full-range gains
      program_gains($urandom, $urandom, $urandom, $urandom, $urandom);
      run_phase(0);

      // small random gains between minus one and one, modest half period
      program_gains(32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000,
                    32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000,
                    32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000,
                    32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000,
                    32'($urandom_range(0, 32'h0001_0000)));
      run_phase(-7);

      if (board.errors == 0 && board.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mobs_pkg.sv
hw/rtl/mobs_ctrl.sv
hw/rtl/mobs_dp.sv
hw/rtl/motion_observer_step.sv
bench/observer_check_pkg.sv
bench/tb.sv
